### rtl/pmid_pkg.sv
package pmid_pkg;

  localparam int unsigned OriginW = 24;
  localparam int unsigned DirW    = 18;
  localparam int unsigned DevW    = 6;
  localparam int unsigned ThrW    = 32;
  localparam int unsigned HoldW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [ThrW-1:0]  PosThrReset  = 32'd241592;
  localparam logic [ThrW-1:0]  DirThrReset  = 32'd343597;
  localparam logic [HoldW-1:0] HoldReset    = 8'd24;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_KEEP   = 2'd1,
    MODE_ACTIVE = 2'd2
  } pmid_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_POS_THR  = 2'd0,
    REG_DIR_THR  = 2'd1,
    REG_HOLD     = 2'd2,
    REG_RESERVED = 2'd3
  } pmid_reg_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } pmid_cmd_e;

  typedef struct packed {
    logic [DevW-1:0]           device_index;
    logic signed [OriginW-1:0] origin_x;
    logic signed [OriginW-1:0] origin_y;
    logic signed [OriginW-1:0] origin_z;
    logic signed [DirW-1:0]    dir_x;
    logic signed [DirW-1:0]    dir_y;
    logic signed [DirW-1:0]    dir_z;
  } pmid_pose_t;

  typedef struct packed {
    pmid_cmd_e  command;
    logic       slot;
    logic       force_update;
    pmid_pose_t pose;
  } pmid_sample_t;

  typedef struct packed {
    logic             valid;
    pmid_pose_t       pose;
    logic [HoldW-1:0] frames_left;
  } pmid_slot_t;

  typedef struct packed {
    logic             write;
    logic             clear;
    logic             slot;
    pmid_pose_t       pose;
    logic [HoldW-1:0] frames_left;
  } pmid_slot_upd_t;

endpackage

### rtl/pmid_if.sv
interface pmid_sample_if;
  logic              valid;
  logic              ready;
  logic              command;
  logic              slot;
  logic              force_update;
  logic [5:0]        device_index;
  logic signed [23:0] origin_x;
  logic signed [23:0] origin_y;
  logic signed [23:0] origin_z;
  logic signed [17:0] dir_x;
  logic signed [17:0] dir_y;
  logic signed [17:0] dir_z;

  modport source (
    output valid, command, slot, force_update, device_index,
    output origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    input  ready
  );
  modport sink (
    input  valid, command, slot, force_update, device_index,
    input  origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    output ready
  );
endinterface

interface pmid_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] update_mode;
  logic       had_history;

  modport source (output valid, update_mode, had_history, input ready);
  modport sink (input valid, update_mode, had_history, output ready);
endinterface

interface pmid_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/pmid_slot_state.sv
module pmid_slot_state (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pmid_pkg::pmid_slot_upd_t upd_i,
  output pmid_pkg::pmid_slot_t     slots_o [2]
);
  import pmid_pkg::*;

  logic             valid_q  [2];
  logic [HoldW-1:0] frames_q [2];
  pmid_pose_t       pose_q   [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0]  <= 1'b0;
      valid_q[1]  <= 1'b0;
      frames_q[0] <= '0;
      frames_q[1] <= '0;
    end else if (upd_i.clear) begin
      valid_q[0]  <= 1'b0;
      valid_q[1]  <= 1'b0;
      frames_q[0] <= '0;
      frames_q[1] <= '0;
    end else if (upd_i.write) begin
      valid_q[upd_i.slot]  <= 1'b1;
      frames_q[upd_i.slot] <= upd_i.frames_left;
    end
  end

  // The stored pose is only looked at while its slot is valid.
  always_ff @(posedge clk_i) begin
    if (upd_i.write && !upd_i.clear) begin
      pose_q[upd_i.slot] <= upd_i.pose;
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      slots_o[i].valid       = valid_q[i];
      slots_o[i].pose        = pose_q[i];
      slots_o[i].frames_left = frames_q[i];
    end
  end

endmodule

### rtl/pmid_motion.sv
module pmid_motion (
  input  pmid_pkg::pmid_pose_t        pose_i,
  input  logic                        force_i,
  input  pmid_pkg::pmid_slot_t        prev_i,
  input  logic [pmid_pkg::ThrW-1:0]   pos_thr_i,
  input  logic [pmid_pkg::ThrW-1:0]   dir_thr_i,
  input  logic [pmid_pkg::HoldW-1:0]  hold_i,
  output pmid_pkg::pmid_mode_e        mode_o,
  output logic                        had_o,
  output logic [pmid_pkg::HoldW-1:0]  frames_o
);
  import pmid_pkg::*;

  logic signed [OriginW:0]     diff_x, diff_y, diff_z;
  logic signed [2*OriginW+1:0] sq_x, sq_y, sq_z;
  logic [2*OriginW+1:0]        pos_sum;
  logic signed [2*DirW-1:0]    prod_x, prod_y, prod_z;
  logic signed [2*DirW+1:0]    dot;
  logic signed [2*DirW+2:0]    dir_delta;
  logic                        pos_moved, dir_moved, active;

  always_comb begin
    diff_x = {pose_i.origin_x[OriginW-1], pose_i.origin_x}
           - {prev_i.pose.origin_x[OriginW-1], prev_i.pose.origin_x};
    diff_y = {pose_i.origin_y[OriginW-1], pose_i.origin_y}
           - {prev_i.pose.origin_y[OriginW-1], prev_i.pose.origin_y};
    diff_z = {pose_i.origin_z[OriginW-1], pose_i.origin_z}
           - {prev_i.pose.origin_z[OriginW-1], prev_i.pose.origin_z};
    sq_x = diff_x * diff_x;
    sq_y = diff_y * diff_y;
    sq_z = diff_z * diff_z;
    pos_sum = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);
    pos_moved = pos_sum > {{(2*OriginW+2-ThrW){1'b0}}, pos_thr_i};

    prod_x = pose_i.dir_x * prev_i.pose.dir_x;
    prod_y = pose_i.dir_y * prev_i.pose.dir_y;
    prod_z = pose_i.dir_z * prev_i.pose.dir_z;
    dot = {{2{prod_x[2*DirW-1]}}, prod_x} + {{2{prod_y[2*DirW-1]}}, prod_y}
        + {{2{prod_z[2*DirW-1]}}, prod_z};

    // Clamping the dot product to [-1, 1] does not change this compare: a dot above one
    // gives a negative delta that never exceeds the threshold, and a dot below minus one
    // gives a delta above two, which always does.
    dir_delta = 39'sh1_0000_0000 - {dot[2*DirW+1], dot};
    dir_moved = dir_delta > $signed({{(2*DirW+3-ThrW){1'b0}}, dir_thr_i});

    had_o  = prev_i.valid && (prev_i.pose.device_index == pose_i.device_index);
    active = force_i || !had_o || pos_moved || dir_moved;

    if (active) begin
      mode_o   = MODE_ACTIVE;
      frames_o = hold_i;
    end else if (prev_i.frames_left != '0) begin
      mode_o   = MODE_KEEP;
      frames_o = prev_i.frames_left - 1'b1;
    end else begin
      mode_o   = MODE_NONE;
      frames_o = prev_i.frames_left;
    end
  end

endmodule

### rtl/pose_motion_idle_detector.sv
// Pose motion idle detector. Each sample transaction yields exactly one result
// transaction, in order, via the input and result registers. A new sample is
// accepted every cycle unless the result side stalls: the per-slot history is read,
// compared and rewritten in the single stage between the input register and the result
// register, so back-to-back samples to the same slot see each other's pose. A clear
// command empties both slots and returns mode none without history. Configuration
// writes are always accepted and should be made while no sample is in flight.
module pose_motion_idle_detector (
  input  logic          clk_i,
  input  logic          rst_ni,
  pmid_sample_if.sink   sample_i,
  pmid_cfg_if.sink      cfg_i,
  pmid_result_if.source result_o
);
  import pmid_pkg::*;

  logic [ThrW-1:0]  pos_thr_q, dir_thr_q;
  logic [HoldW-1:0] hold_q;

  logic         s1_valid_q;
  pmid_sample_t s1_q;
  logic         s1_fire;

  logic       res_valid_q;
  pmid_mode_e res_mode_q, res_mode_d;
  logic       res_had_q, res_had_d;

  pmid_slot_t     slots [2];
  pmid_slot_t     prev;
  pmid_slot_upd_t upd;
  pmid_mode_e     calc_mode;
  logic           calc_had;
  logic [HoldW-1:0] calc_frames;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_thr_q <= PosThrReset;
      dir_thr_q <= DirThrReset;
      hold_q    <= HoldReset;
    end else if (cfg_i.valid) begin
      unique case (pmid_reg_e'(cfg_i.index))
        REG_POS_THR:  pos_thr_q <= cfg_i.data;
        REG_DIR_THR:  dir_thr_q <= cfg_i.data;
        REG_HOLD:     hold_q    <= cfg_i.data[HoldW-1:0];
        REG_RESERVED: ;
        default:      ;
      endcase
    end
  end

  assign s1_fire        = s1_valid_q && (!res_valid_q || result_o.ready);
  assign sample_i.ready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      s1_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      s1_q.command           <= pmid_cmd_e'(sample_i.command);
      s1_q.slot              <= sample_i.slot;
      s1_q.force_update      <= sample_i.force_update;
      s1_q.pose.device_index <= sample_i.device_index;
      s1_q.pose.origin_x     <= sample_i.origin_x;
      s1_q.pose.origin_y     <= sample_i.origin_y;
      s1_q.pose.origin_z     <= sample_i.origin_z;
      s1_q.pose.dir_x        <= sample_i.dir_x;
      s1_q.pose.dir_y        <= sample_i.dir_y;
      s1_q.pose.dir_z        <= sample_i.dir_z;
    end
  end

  assign prev = slots[s1_q.slot];

  pmid_motion u_motion (
    .pose_i    (s1_q.pose),
    .force_i   (s1_q.force_update),
    .prev_i    (prev),
    .pos_thr_i (pos_thr_q),
    .dir_thr_i (dir_thr_q),
    .hold_i    (hold_q),
    .mode_o    (calc_mode),
    .had_o     (calc_had),
    .frames_o  (calc_frames)
  );

  always_comb begin
    upd.write       = s1_fire && (s1_q.command == CMD_SAMPLE);
    upd.clear       = s1_fire && (s1_q.command == CMD_CLEAR);
    upd.slot        = s1_q.slot;
    upd.pose        = s1_q.pose;
    upd.frames_left = calc_frames;
    if (s1_q.command == CMD_CLEAR) begin
      res_mode_d = MODE_NONE;
      res_had_d  = 1'b0;
    end else begin
      res_mode_d = calc_mode;
      res_had_d  = calc_had;
    end
  end

  pmid_slot_state u_slot_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd),
    .slots_o (slots)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_fire) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_mode_q <= res_mode_d;
      res_had_q  <= res_had_d;
    end
  end

  assign result_o.valid       = res_valid_q;
  assign result_o.update_mode = res_mode_q;
  assign result_o.had_history = res_had_q;

  a_keep_needs_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (res_mode_q == MODE_KEEP) |-> res_had_q)
    else $error("keep-alive result without matching history");

  a_clear_empties_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (s1_q.command == CMD_CLEAR) |=> !slots[0].valid && !slots[1].valid)
    else $error("slot still valid after a clear transaction");

  a_sample_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (s1_q.command == CMD_SAMPLE) |=> slots[$past(s1_q.slot)].valid)
    else $error("slot not valid after a sample transaction");

  a_ready_when_result_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_q |-> sample_i.ready)
    else $error("sample side stalled with an empty result register");

endmodule

### tb/sv/pmid_motion_checker.sv
module pmid_motion_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  pmid_sample_if      sample_i,
  pmid_cfg_if         cfg_i,
  pmid_result_if      result_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  import pmid_pkg::*;

  localparam longint UnitQ32 = longint'(1) << 32;

  typedef struct packed {
    pmid_mode_e mode;
    logic       had_history;
  } motion_verdict_t;

  logic [ThrW-1:0]  pos_limit_sq;
  logic [ThrW-1:0]  turn_limit;
  logic [HoldW-1:0] hold_reload;
  pmid_pose_t       last_pose [2];
  logic             pose_known [2];
  logic [HoldW-1:0] hold_left [2];
  motion_verdict_t  verdicts_due [$];
  int unsigned      mismatches;

  function automatic void forget_poses();
    int k;
    for (k = 0; k < 2; k++) begin
      last_pose[k] = '0;
      pose_known[k] = 1'b0;
      hold_left[k] = '0;
    end
  endfunction

  function automatic longint sq_step(input logic signed [OriginW-1:0] a,
                                     input logic signed [OriginW-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return d * d;
  endfunction

  function automatic motion_verdict_t judge_motion(input pmid_sample_t s);
    motion_verdict_t v;
    pmid_pose_t      was;
    longint          travel_sq;
    longint          dot;
    logic            moved;
    v.mode = MODE_NONE;
    v.had_history = 1'b0;
    if (s.command == CMD_CLEAR) begin
      forget_poses();
      return v;
    end
    was = last_pose[s.slot];
    v.had_history = pose_known[s.slot] && (was.device_index == s.pose.device_index);
    moved = 1'b1;
    if (!s.force_update && v.had_history) begin
      travel_sq = sq_step(s.pose.origin_x, was.origin_x)
                + sq_step(s.pose.origin_y, was.origin_y)
                + sq_step(s.pose.origin_z, was.origin_z);
      dot = longint'($signed(s.pose.dir_x)) * longint'($signed(was.dir_x))
          + longint'($signed(s.pose.dir_y)) * longint'($signed(was.dir_y))
          + longint'($signed(s.pose.dir_z)) * longint'($signed(was.dir_z));
      if (dot > UnitQ32) dot = UnitQ32;
      if (dot < -UnitQ32) dot = -UnitQ32;
      moved = (travel_sq > longint'(pos_limit_sq)) || ((UnitQ32 - dot) > longint'(turn_limit));
    end
    last_pose[s.slot] = s.pose;
    pose_known[s.slot] = 1'b1;
    if (moved) begin
      hold_left[s.slot] = hold_reload;
      v.mode = MODE_ACTIVE;
    end else if (hold_left[s.slot] != '0) begin
      hold_left[s.slot] = hold_left[s.slot] - 1'b1;
      v.mode = MODE_KEEP;
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pmid_sample_t    taken;
    motion_verdict_t want;
    if (!rst_ni) begin
      pos_limit_sq = PosThrReset;
      turn_limit = DirThrReset;
      hold_reload = HoldReset;
      forget_poses();
      verdicts_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (pmid_reg_e'(cfg_i.index))
          REG_POS_THR: pos_limit_sq = cfg_i.data;
          REG_DIR_THR: turn_limit = cfg_i.data;
          REG_HOLD: hold_reload = cfg_i.data[HoldW-1:0];
          default: ;
        endcase
      end
      if (result_i.valid && result_i.ready) begin
        if (verdicts_due.size() == 0) begin
          $error("result transaction with no sample outstanding");
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          if (result_i.update_mode !== want.mode) begin
            $error("update_mode: expected %0d, actual %0d", want.mode, result_i.update_mode);
            mismatches++;
          end
          if (result_i.had_history !== want.had_history) begin
            $error("had_history: expected %0d, actual %0d", want.had_history,
                   result_i.had_history);
            mismatches++;
          end
        end
      end
      if (sample_i.valid && sample_i.ready) begin
        taken.command = pmid_cmd_e'(sample_i.command);
        taken.slot = sample_i.slot;
        taken.force_update = sample_i.force_update;
        taken.pose.device_index = sample_i.device_index;
        taken.pose.origin_x = sample_i.origin_x;
        taken.pose.origin_y = sample_i.origin_y;
        taken.pose.origin_z = sample_i.origin_z;
        taken.pose.dir_x = sample_i.dir_x;
        taken.pose.dir_y = sample_i.dir_y;
        taken.pose.dir_z = sample_i.dir_z;
        verdicts_due = {verdicts_due, judge_motion(taken)};
      end
    end
    mismatch_count_o <= mismatches;
    pending_o <= verdicts_due.size();
  end

endmodule

### tb/sv/tb_top.sv
module tb_top;
  import pmid_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam logic signed [DirW-1:0]    Unit = 18'sd65536;
  localparam logic signed [OriginW-1:0] OMax = {1'b0, {(OriginW-1){1'b1}}};
  localparam logic signed [OriginW-1:0] OMin = {1'b1, {(OriginW-1){1'b0}}};
  localparam logic signed [DirW-1:0]    DMax = {1'b0, {(DirW-1){1'b1}}};
  localparam logic signed [DirW-1:0]    DMin = {1'b1, {(DirW-1){1'b0}}};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned gap_pct;
  int unsigned stall_pct;
  pmid_pose_t  walk_pose [2];

  pmid_sample_if sample_if ();
  pmid_cfg_if    cfg_if ();
  pmid_result_if result_if ();

  pose_motion_idle_detector DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .cfg_i    (cfg_if),
    .result_o (result_if)
  );

  pmid_motion_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sample_i         (sample_if),
    .cfg_i            (cfg_if),
    .result_i         (result_if),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always #4 clk_i = ~clk_i;

  function automatic pmid_sample_t make_sample(
    input pmid_cmd_e cmd, input logic slot, input logic force_upd, input logic [DevW-1:0] dev,
    input logic signed [OriginW-1:0] ox, input logic signed [OriginW-1:0] oy,
    input logic signed [OriginW-1:0] oz, input logic signed [DirW-1:0] dx,
    input logic signed [DirW-1:0] dy, input logic signed [DirW-1:0] dz);
    pmid_sample_t s;
    s.command = cmd;
    s.slot = slot;
    s.force_update = force_upd;
    s.pose.device_index = dev;
    s.pose.origin_x = ox;
    s.pose.origin_y = oy;
    s.pose.origin_z = oz;
    s.pose.dir_x = dx;
    s.pose.dir_y = dy;
    s.pose.dir_z = dz;
    return s;
  endfunction

  function automatic logic [OriginW-1:0] jiggle(input logic [OriginW-1:0] base,
                                                input int unsigned span);
    return base + OriginW'($urandom_range(0, 2 * span)) - OriginW'(span);
  endfunction

  function automatic int unsigned pick_span(input int unsigned a, input int unsigned b,
                                            input int unsigned c);
    case ($urandom_range(0, 5))
      0, 1: return 0;
      2: return a;
      3: return b;
      4: return c;
      default: return c * 12;
    endcase
  endfunction

  // Most samples walk a per-hand pose with small jitter so that the hold
  // counter actually runs down; the rest are clears and unrelated poses.
  function automatic pmid_sample_t random_sample();
    pmid_sample_t               s;
    int unsigned                pick;
    int unsigned                reach;
    int unsigned                sway;
    logic signed [DirW-1:0]     axis;
    pick = $urandom_range(0, 99);
    s = make_sample(CMD_SAMPLE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    DevW'($urandom_range(0, 63)), OriginW'($urandom()), OriginW'($urandom()),
                    OriginW'($urandom()), DirW'($urandom()), DirW'($urandom()),
                    DirW'($urandom()));
    if (pick < 3) begin
      s.command = CMD_CLEAR;
    end else if (pick >= 13) begin
      s.force_update = ($urandom_range(0, 99) < 5);
      if ($urandom_range(0, 99) >= 4) s.pose.device_index = walk_pose[s.slot].device_index;
      reach = pick_span(40, 200, 400);
      sway = pick_span(2, 6, 40);
      s.pose.origin_x = jiggle(walk_pose[s.slot].origin_x, reach);
      s.pose.origin_y = jiggle(walk_pose[s.slot].origin_y, reach);
      s.pose.origin_z = jiggle(walk_pose[s.slot].origin_z, reach);
      if ($urandom_range(0, 99) < 3) begin
        axis = $urandom_range(0, 1) ? Unit : -Unit;
        s.pose.dir_x = '0;
        s.pose.dir_y = '0;
        s.pose.dir_z = '0;
        case ($urandom_range(0, 2))
          0: s.pose.dir_x = axis;
          1: s.pose.dir_y = axis;
          default: s.pose.dir_z = axis;
        endcase
      end else begin
        s.pose.dir_x = DirW'(jiggle(OriginW'(walk_pose[s.slot].dir_x), sway));
        s.pose.dir_y = DirW'(jiggle(OriginW'(walk_pose[s.slot].dir_y), sway));
        s.pose.dir_z = DirW'(jiggle(OriginW'(walk_pose[s.slot].dir_z), sway));
      end
      walk_pose[s.slot] = s.pose;
    end
    return s;
  endfunction

  task automatic send_sample(input pmid_sample_t s);
    if ($urandom_range(0, 99) < gap_pct) begin
      sample_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    sample_if.command <= s.command;
    sample_if.slot <= s.slot;
    sample_if.force_update <= s.force_update;
    sample_if.device_index <= s.pose.device_index;
    sample_if.origin_x <= s.pose.origin_x;
    sample_if.origin_y <= s.pose.origin_y;
    sample_if.origin_z <= s.pose.origin_z;
    sample_if.dir_x <= s.pose.dir_x;
    sample_if.dir_y <= s.pose.dir_y;
    sample_if.dir_z <= s.pose.dir_z;
    sample_if.valid <= 1'b1;
    do @(posedge clk_i); while (!sample_if.ready);
  endtask

  task automatic wait_drained();
    sample_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(input pmid_reg_e idx, input logic [CfgDataW-1:0] value);
    cfg_if.index <= idx;
    cfg_if.data <= value;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic configure(input logic [ThrW-1:0] pos_thr, input logic [ThrW-1:0] dir_thr,
                           input logic [HoldW-1:0] hold);
    wait_drained();
    put_reg(REG_POS_THR, pos_thr);
    put_reg(REG_DIR_THR, dir_thr);
    put_reg(REG_HOLD, CfgDataW'(hold));
    put_reg(REG_RESERVED, $urandom());
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(posedge clk_i);
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("FAIL pose_motion_idle_detector");
    $finish;
  end

  initial begin
    int           phase;
    pmid_sample_t seed;
    rst_ni <= 1'b0;
    sample_if.valid <= 1'b0;
    sample_if.command <= CMD_SAMPLE;
    sample_if.slot <= 1'b0;
    sample_if.force_update <= 1'b0;
    sample_if.device_index <= '0;
    sample_if.origin_x <= '0;
    sample_if.origin_y <= '0;
    sample_if.origin_z <= '0;
    sample_if.dir_x <= '0;
    sample_if.dir_y <= '0;
    sample_if.dir_z <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_POS_THR;
    cfg_if.data <= '0;
    gap_pct = 10;
    stall_pct = 10;
    seed = make_sample(CMD_SAMPLE, 0, 0, 6'd5, 24'sd1000, -24'sd2000, 24'sd3000, Unit, 0, 0);
    walk_pose[0] = seed.pose;
    seed = make_sample(CMD_SAMPLE, 1, 0, 6'd9, -24'sd50000, 24'sd70000, 24'sd0, 0, 0, -Unit);
    walk_pose[1] = seed.pose;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_sample(make_sample(CMD_SAMPLE, 0, 0, 6'd5, 24'sd1000, -24'sd2000, 24'sd3000, Unit, 0, 0));
    send_sample(make_sample(CMD_SAMPLE, 0, 0, 6'd5, 24'sd1000, -24'sd2000, 24'sd3000, Unit, 0, 0));
    send_sample(make_sample(CMD_SAMPLE, 0, 0, 6'd5, 24'sd1100, -24'sd1900, 24'sd3100, Unit, 0, 0));
    send_sample(make_sample(CMD_SAMPLE, 0, 0, 6'd5, 24'sd2100, -24'sd1900, 24'sd3100, Unit, 0, 0));
    send_sample(make_sample(CMD_SAMPLE, 0, 0, 6'd5, 24'sd2100, -24'sd1900, 24'sd3100,
                            Unit - 18'sd8, 18'sd8, 0));
    send_sample(make_sample(CMD_SAMPLE, 0, 1, 6'd5, 24'sd2100, -24'sd1900, 24'sd3100,
                            Unit - 18'sd8, 18'sd8, 0));
    send_sample(make_sample(CMD_SAMPLE, 0, 0, 6'd63, 24'sd2100, -24'sd1900, 24'sd3100, Unit, 0, 0));
    send_sample(make_sample(CMD_SAMPLE, 0, 0, 6'd63, 24'sd2100, -24'sd1900, 24'sd3100, Unit, 0, 0));
    send_sample(make_sample(CMD_SAMPLE, 1, 0, 6'd0, OMax, OMax, OMax, DMax, DMax, DMax));
    send_sample(make_sample(CMD_SAMPLE, 1, 0, 6'd0, OMax, OMax, OMax, DMax, DMax, DMax));
    send_sample(make_sample(CMD_SAMPLE, 1, 0, 6'd0, OMin, OMin, OMin, DMin, DMin, DMin));
    send_sample(make_sample(CMD_SAMPLE, 1, 0, 6'd0, OMax, OMax, OMax, DMax, DMax, DMax));
    send_sample(make_sample(CMD_CLEAR, 1, 1, 6'd63, OMax, OMin, OMax, DMin, DMax, DMin));
    send_sample(make_sample(CMD_SAMPLE, 0, 0, 6'd63, 24'sd2100, -24'sd1900, 24'sd3100, Unit, 0, 0));
    send_sample(make_sample(CMD_SAMPLE, 1, 0, 6'd0, OMax, OMax, OMax, DMax, DMax, DMax));

    configure('0, '0, '0);
    send_sample(make_sample(CMD_SAMPLE, 0, 0, 6'd63, 24'sd2100, -24'sd1900, 24'sd3100, Unit, 0, 0));
    send_sample(make_sample(CMD_SAMPLE, 0, 0, 6'd63, 24'sd2101, -24'sd1900, 24'sd3100, Unit, 0, 0));
    send_sample(make_sample(CMD_SAMPLE, 0, 0, 6'd63, 24'sd2101, -24'sd1900, 24'sd3100, Unit, 0, 0));
    send_sample(make_sample(CMD_SAMPLE, 0, 1, 6'd63, 24'sd2101, -24'sd1900, 24'sd3100, Unit, 0, 0));

    configure('1, '1, '1);
    send_sample(make_sample(CMD_SAMPLE, 0, 0, 6'd63, 24'sd2101, -24'sd1900, 24'sd3100, Unit, 0, 0));
    send_sample(make_sample(CMD_SAMPLE, 0, 0, 6'd63, OMin, OMax, OMin, Unit, 0, 0));
    send_sample(make_sample(CMD_SAMPLE, 0, 0, 6'd63, OMin, OMax, OMin, -Unit, 0, 0));
    send_sample(make_sample(CMD_SAMPLE, 0, 0, 6'd63, OMin, OMax, OMin, -Unit, 0, 0));

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          configure(PosThrReset, DirThrReset, HoldReset);
          gap_pct = 10;
          stall_pct = 10;
        end
        1: begin
          configure($urandom_range(0, 2000000), $urandom_range(0, 2000000),
                    HoldW'($urandom_range(1, 6)));
          gap_pct = 30;
          stall_pct = 30;
        end
        2: begin
          configure('0, '0, '0);
          gap_pct = 20;
          stall_pct = 5;
        end
        3: begin
          configure('1, '1, '1);
          gap_pct = 5;
          stall_pct = 25;
        end
        4: begin
          configure($urandom(), $urandom(), HoldW'($urandom_range(0, 255)));
          gap_pct = 15;
          stall_pct = 15;
        end
        default: begin
          configure(PosThrReset, DirThrReset, 8'd3);
          gap_pct = 0;
          stall_pct = 0;
        end
      endcase
      repeat (88) send_sample(random_sample());
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS pose_motion_idle_detector");
    end else begin
      $display("FAIL pose_motion_idle_detector");
    end
    $finish;
  end

endmodule
